FILE: src/kst_pkg.sv
`default_nettype none

package kst_pkg;

    localparam int unsigned KEY_W        = 32;
    localparam int unsigned OP_W         = 2;
    localparam int unsigned COUNT_W      = 5;
    localparam int unsigned CAPACITY_DEF = 16;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef struct packed {
        logic               found;
        logic               accepted;
        logic [COUNT_W-1:0] count;
    } t_result;

endpackage

`default_nettype wire

FILE: src/kst_scan.sv
`default_nettype none

module kst_scan #(
    parameter int unsigned CAPACITY = kst_pkg::CAPACITY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    output logic                               o_req_ready,
    input  wire logic [kst_pkg::OP_W-1:0]      i_operation,
    input  wire logic [kst_pkg::KEY_W-1:0]     i_key,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output kst_pkg::t_result                   o_res
);
    import kst_pkg::*;

    localparam int unsigned OW = $clog2(CAPACITY + 1);
    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    logic [OW-1:0]      r_occ, n_occ;
    logic [OW-1:0]      r_idx, n_idx;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_slot, n_slot;
    t_op                r_op, n_op;
    logic [KEY_W-1:0]   r_key, n_key;
    logic               r_found, n_found;
    logic               r_acc, n_acc;

    // key store, one write and one registered read port
    logic [KEY_W-1:0]   r_mem [CAPACITY];
    logic [KEY_W-1:0]   r_rdata;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [KEY_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;

    logic               hit;
    logic [OW-1:0]      idx_prev;
    logic [OW-1:0]      occ_last;

    assign hit      = r_pend && (r_rdata == r_key);
    assign idx_prev = r_idx - OW'(1);
    assign occ_last = r_occ - OW'(1);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_slot    = r_slot;
        n_op      = r_op;
        n_key     = r_key;
        n_found   = r_found;
        n_acc     = r_acc;
        mem_we    = 1'b0;
        mem_waddr = r_occ[AW-1:0];
        mem_wdata = r_key;
        mem_re    = 1'b0;
        mem_raddr = r_idx[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_op    = t_op'(i_operation);
                    n_key   = i_key;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    n_acc   = 1'b1;
                    if (t_op'(i_operation) == OP_CLEAR) begin
                        n_occ   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                n_pend = 1'b0;
                if (hit) begin
                    n_found = 1'b1;
                    if (r_op == OP_REMOVE) begin
                        // fetch the last held key to fill the hole
                        mem_re    = 1'b1;
                        mem_raddr = occ_last[AW-1:0];
                        n_slot    = idx_prev[AW-1:0];
                        n_state   = S_MOVE;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_idx < r_occ) begin
                    mem_re = 1'b1;
                    n_idx  = r_idx + OW'(1);
                    n_pend = 1'b1;
                end else begin
                    // scan ran out without a match
                    if (r_op == OP_INSERT) begin
                        if (r_occ == OW'(CAPACITY)) begin
                            n_acc = 1'b0;
                        end else begin
                            mem_we = 1'b1;
                            n_occ  = r_occ + OW'(1);
                        end
                    end
                    n_state = S_DONE;
                end
            end
            S_MOVE: begin
                mem_we    = 1'b1;
                mem_waddr = r_slot;
                mem_wdata = r_rdata;
                n_occ     = occ_last;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_pend  <= n_pend;
        end
        r_idx   <= n_idx;
        r_slot  <= n_slot;
        r_op    <= n_op;
        r_key   <= n_key;
        r_found <= n_found;
        r_acc   <= n_acc;
    end

    assign o_req_ready    = (r_state == S_IDLE);
    assign o_res_valid    = (r_state == S_DONE);
    assign o_res.found    = r_found;
    assign o_res.accepted = r_acc;
    assign o_res.count    = COUNT_W'(r_occ);

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(CAPACITY))
        else $error("occupancy above capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready && t_op'(i_operation) == OP_CLEAR) |=> (r_occ == '0))
        else $error("clear left keys behind");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_SCAN || r_state == S_MOVE))
        else $error("key store written outside scan or move");

    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_MOVE) |=>
            (r_occ == $past(r_occ) || r_occ == $past(r_occ) + OW'(1)
             || r_occ == $past(r_occ) - OW'(1)))
        else $error("occupancy moved by more than one");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.accepted) |-> (r_op == OP_INSERT && r_occ == OW'(CAPACITY)))
        else $error("insert rejected while table not full");
`endif

endmodule

`default_nettype wire

FILE: src/key_set_table.sv
// key_set_table: bounded set of signed 32-bit keys in an unordered table
// request channel: i_in_valid / o_in_ready with i_operation (clear, lookup,
//   insert, remove) and i_key; a request is taken when both are high
// result channel: o_out_valid / i_out_ready with o_found, o_accepted and
//   o_count (keys held after the request, low 5 bits)
// one result for every request, in request order
// timing: clear skips the scan; other requests scan the held
//   keys one per cycle through the key store's read port (remove on a match
//   adds a step to fetch the last key and write it into the freed slot)
// one request in the scan at a time, set by the linear scan of the key
//   store through its one read port
// the result sits in an output register, so the next request is taken
//   while a result still waits for i_out_ready; if the receiver stalls
//   longer, the finished next result is held inside and o_in_ready drops
// reset (i_rst_n low, synchronous) empties the set and drops both valids;
//   the key store itself is not cleared, the count keeps stale keys unseen
`default_nettype none

module key_set_table #(
    parameter int unsigned CAPACITY = kst_pkg::CAPACITY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [kst_pkg::OP_W-1:0]      i_operation,
    input  wire logic signed [kst_pkg::KEY_W-1:0] i_key,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_found,
    output logic                               o_accepted,
    output logic [kst_pkg::COUNT_W-1:0]        o_count
);
    import kst_pkg::*;

    logic               res_valid;
    logic               res_ready;
    t_result            res;

    // output register
    logic               r_out_valid;
    t_result            r_out;

    kst_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_operation (i_operation),
        .i_key       (i_key),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // free when empty or being drained this cycle
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out.found;
    assign o_accepted  = r_out.accepted;
    assign o_count     = r_out.count;

endmodule

`default_nettype wire

FILE: test/kst_scoreboard_pkg.sv
package kst_scoreboard_pkg;

    import kst_pkg::*;

    class key_set_scoreboard;
        // shadow copy of the set: held_keys[0 .. held_count-1] are live
        logic [KEY_W-1:0] held_keys [CAPACITY_DEF];
        int unsigned      held_count;
        t_result          pending_results [$];

        int unsigned      n_errors;
        int unsigned      n_checked;
        int unsigned      n_ops [4];
        int unsigned      n_full_reject;
        int unsigned      n_remove_hit;
        int unsigned      n_insert_dup;

        function new();
            held_count    = 0;
            n_errors      = 0;
            n_checked     = 0;
            n_full_reject = 0;
            n_remove_hit  = 0;
            n_insert_dup  = 0;
            foreach (n_ops[i]) n_ops[i] = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            n_errors++;
        endtask

        // update the shadow set for one accepted request and queue its result
        function void note_request(input t_op op, input logic [KEY_W-1:0] key);
            t_result res;
            int      slot;
            res.found    = 1'b0;
            res.accepted = 1'b1;
            slot         = -1;
            for (int i = 0; i < held_count; i++) begin
                if (slot < 0 && held_keys[i] == key) slot = i;
            end
            n_ops[op]++;
            case (op)
                OP_CLEAR: begin
                    held_count = 0;
                end
                OP_LOOKUP: begin
                    res.found = (slot >= 0);
                end
                OP_INSERT: begin
                    if (slot >= 0) begin
                        res.found = 1'b1;
                        n_insert_dup++;
                    end else if (held_count >= CAPACITY_DEF) begin
                        res.accepted = 1'b0;
                        n_full_reject++;
                    end else begin
                        held_keys[held_count] = key;
                        held_count++;
                    end
                end
                OP_REMOVE: begin
                    // last held entry moves into the freed slot
                    if (slot >= 0) begin
                        res.found       = 1'b1;
                        held_keys[slot] = held_keys[held_count - 1];
                        held_count--;
                        n_remove_hit++;
                    end
                end
                default: ;
            endcase
            res.count = COUNT_W'(held_count);
            pending_results.push_back(res);
        endfunction

        task check_result(input logic found, input logic accepted,
                          input logic [COUNT_W-1:0] count);
            t_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("result %0d arrived with none outstanding", n_checked));
            end else begin
                want = pending_results.pop_front();
                if (found !== want.found)
                    report($sformatf("result %0d found %b, want %b",
                                     n_checked, found, want.found));
                if (accepted !== want.accepted)
                    report($sformatf("result %0d accepted %b, want %b",
                                     n_checked, accepted, want.accepted));
                if (count !== want.count)
                    report($sformatf("result %0d count %0d, want %0d",
                                     n_checked, count, want.count));
            end
            n_checked++;
        endtask
    endclass

endpackage

FILE: test/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import kst_pkg::*;
    import kst_scoreboard_pkg::*;

    // run sizing
    localparam int unsigned RANDOM_REQUESTS = 1800;
    localparam int unsigned POOL_SIZE       = 20;    // a bit over capacity so the table fills
    localparam int unsigned LONG_HOLD       = 400;   // receiver back-pressure stretch
    localparam int unsigned HOLD_AFTER      = 300;   // results checked before the stretch
    localparam int unsigned DRAIN_CYCLES    = 3 * (CAPACITY_DEF + 4);
    localparam int unsigned CYCLE_LIMIT     = 500_000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [OP_W-1:0]         i_operation;
    logic signed [KEY_W-1:0] i_key;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic                    o_found;
    logic                    o_accepted;
    logic [COUNT_W-1:0]      o_count;

    key_set_scoreboard       sb;
    int unsigned             cycle_count;
    int unsigned             n_sent;
    bit                      draining;
    logic [KEY_W-1:0]        key_pool [POOL_SIZE];

    key_set_table #(
        .CAPACITY (CAPACITY_DEF)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_key       (i_key),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_found     (o_found),
        .o_accepted  (o_accepted),
        .o_count     (o_count)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: a hung handshake ends the run as a failure
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending_results.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // draw an idle gap; every third stretch of 64 items runs back to back
    function automatic int unsigned draw_gap(input int unsigned idx);
        if ((idx / 64) % 3 == 0) return 0;
        return $urandom_range(0, 13);
    endfunction

    // present one request after a random gap and hold it until taken;
    // returns right after the accepting rising edge
    task automatic send_request(input t_op op, input logic [KEY_W-1:0] key);
        int unsigned gap;
        gap = draw_gap(n_sent);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_operation = op;
        i_key       = key;
        // handshake is judged on the values just before the edge
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(op, key);
        n_sent++;
    endtask

    // result side: random stalls, one long hold-off, then check each result
    initial begin : result_sink
        int unsigned gap;
        bit          hold_done;
        hold_done = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (draining) begin
                gap = 0;
            end else if (!hold_done && sb.n_checked >= HOLD_AFTER) begin
                // long stall so the block fills and drops o_in_ready
                gap       = LONG_HOLD;
                hold_done = 1'b1;
            end else begin
                gap = draw_gap(sb.n_checked + 32);
            end
            @(negedge i_clk);
            if (gap > 0) begin
                i_out_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result(o_found, o_accepted, o_count);
        end
    end

    initial begin : stimulus
        int unsigned      pick;
        int unsigned      insert_weight;
        t_op              op;
        logic [KEY_W-1:0] key;

        sb          = new();
        n_sent      = 0;
        draining    = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_ready = 1'b0;
        i_operation = OP_CLEAR;
        i_key       = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty-set corner cases
        send_request(OP_LOOKUP, 32'h0000_0000);
        send_request(OP_REMOVE, 32'h0000_0000);    // remove of an absent key
        send_request(OP_CLEAR,  32'hFFFF_FFFF);
        // fill to capacity, key extremes first
        send_request(OP_INSERT, 32'h8000_0000);
        send_request(OP_INSERT, 32'h7FFF_FFFF);
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_INSERT, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h5555_5555);
        send_request(OP_INSERT, 32'hAAAA_AAAA);
        send_request(OP_INSERT, 32'h0000_0001);
        for (int i = 0; i < 9; i++)
            send_request(OP_INSERT, 32'h0F0F_0F00 + i);
        send_request(OP_INSERT, 32'h0000_0007);    // table full, rejected
        send_request(OP_INSERT, 32'h7FFF_FFFF);    // already present while full
        send_request(OP_REMOVE, 32'h0F0F_0F08);    // last held entry
        send_request(OP_REMOVE, 32'h8000_0000);    // first slot, back-filled
        send_request(OP_REMOVE, 32'h0000_0007);    // absent
        send_request(OP_LOOKUP, 32'h7FFF_FFFF);
        send_request(OP_CLEAR,  32'h0000_0000);
        send_request(OP_LOOKUP, 32'h7FFF_FFFF);    // gone after clear

        // random: mostly keys from a small pool so hits, fills and
        // back-fills happen often; some fully random keys for bit coverage
        insert_weight = 50;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 300 == 0) begin
                foreach (key_pool[i]) key_pool[i] = $urandom();
            end
            if (n % 150 == 0) begin
                // switch at random among three insert weights
                case ($urandom_range(0, 2))
                    0:       insert_weight = 35;
                    1:       insert_weight = 50;
                    default: insert_weight = 65;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
                op = OP_CLEAR;
            else if (pick < 3 + insert_weight)
                op = OP_INSERT;
            else if (pick < 3 + insert_weight + (97 - insert_weight) / 2)
                op = OP_LOOKUP;
            else
                op = OP_REMOVE;
            if ($urandom_range(0, 99) < 85)
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                key = $urandom();
            send_request(op, key);
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        draining   = 1'b1;

        // wait for every result, then watch for strays
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d clear, %0d lookup, %0d insert, %0d remove",
                 n_sent, sb.n_ops[OP_CLEAR], sb.n_ops[OP_LOOKUP],
                 sb.n_ops[OP_INSERT], sb.n_ops[OP_REMOVE]);
        $display("full-table rejects %0d, duplicate inserts %0d, remove hits %0d, %0d mismatches",
                 sb.n_full_reject, sb.n_insert_dup, sb.n_remove_hit, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
